// ===== sv/etpwm_pkg.sv =====
// Shared constants, register indexes and configuration type for the PWM ramp profile unit.
package etpwm_pkg;

	// Configuration port geometry
	localparam int unsigned CFG_IDX_W  = 4;
	localparam int unsigned CFG_DATA_W = 32;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_PWM    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_PWM     = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FINAL_PWM      = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEPS     = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_INTERVAL  = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DECEL_FRACTION = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MOVE_PULSES    = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_BACKWARD       = 4'd7;

	// Field widths
	localparam int unsigned STEPS_W    = 8;
	localparam int unsigned INTERVAL_W = 16;
	localparam int unsigned FRAC_W     = 9;
	localparam int unsigned PULSES_W   = 31;
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned COUNT_W    = 32;
	localparam int unsigned STEP_CNT_W = 9;

	// Reset values
	localparam logic [STEPS_W-1:0]    RST_RAMP_STEPS     = 8'd20;
	localparam logic [INTERVAL_W-1:0] RST_STEP_INTERVAL  = 16'd20;
	localparam logic [FRAC_W-1:0]     RST_DECEL_FRACTION = 9'd179;
	localparam int unsigned           RST_TARGET_PWM     = 255;

	// Non-PWM configuration fields
	typedef struct packed {
		logic [STEPS_W-1:0]    ramp_steps;
		logic [INTERVAL_W-1:0] step_interval_ms;
		logic [FRAC_W-1:0]     decel_fraction;
		logic [PULSES_W-1:0]   move_pulses;
		logic                  backward;
	} cfg_t;

endpackage

// ===== sv/etpwm_cfg_regs.sv =====
// Configuration register file of the PWM ramp profile unit.
module etpwm_cfg_regs #(
	parameter int unsigned PWM_WIDTH = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [etpwm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [etpwm_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic [PWM_WIDTH-1:0]                  initial_pwm,
	output logic [PWM_WIDTH-1:0]                  target_pwm,
	output logic [PWM_WIDTH-1:0]                  final_pwm,
	output etpwm_pkg::cfg_t                       cfg
);

	logic [PWM_WIDTH-1:0] initial_q;
	logic [PWM_WIDTH-1:0] target_q;
	logic [PWM_WIDTH-1:0] final_q;
	etpwm_pkg::cfg_t      cfg_q;
	logic                 wr_en;

	// Writes must be made only while idle; this is not enforced, and the port is always open
	assign cfg_ready = 1'b1;
	assign wr_en     = cfg_valid & cfg_ready;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_q              <= '0;
			target_q               <= PWM_WIDTH'(etpwm_pkg::RST_TARGET_PWM);
			final_q                <= '0;
			cfg_q.ramp_steps       <= etpwm_pkg::RST_RAMP_STEPS;
			cfg_q.step_interval_ms <= etpwm_pkg::RST_STEP_INTERVAL;
			cfg_q.decel_fraction   <= etpwm_pkg::RST_DECEL_FRACTION;
			cfg_q.move_pulses      <= '0;
			cfg_q.backward         <= 1'b0;
		end else if (wr_en) begin
			case (cfg_index)
				etpwm_pkg::REG_INITIAL_PWM: initial_q <= cfg_data[PWM_WIDTH-1:0];
				etpwm_pkg::REG_TARGET_PWM:  target_q  <= cfg_data[PWM_WIDTH-1:0];
				etpwm_pkg::REG_FINAL_PWM:   final_q   <= cfg_data[PWM_WIDTH-1:0];
				etpwm_pkg::REG_RAMP_STEPS:
					cfg_q.ramp_steps <= cfg_data[etpwm_pkg::STEPS_W-1:0];
				etpwm_pkg::REG_STEP_INTERVAL:
					cfg_q.step_interval_ms <= cfg_data[etpwm_pkg::INTERVAL_W-1:0];
				etpwm_pkg::REG_DECEL_FRACTION:
					cfg_q.decel_fraction <= cfg_data[etpwm_pkg::FRAC_W-1:0];
				etpwm_pkg::REG_MOVE_PULSES:
					cfg_q.move_pulses <= cfg_data[etpwm_pkg::PULSES_W-1:0];
				etpwm_pkg::REG_BACKWARD:    cfg_q.backward <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign initial_pwm = initial_q;
	assign target_pwm  = target_q;
	assign final_pwm   = final_q;
	assign cfg         = cfg_q;

endmodule

// ===== sv/etpwm_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle (32-bit dividend by 8-bit divisor).
module etpwm_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [etpwm_pkg::TIME_W-1:0]      dividend,
	input  logic [etpwm_pkg::STEPS_W-1:0]     divisor,
	output logic                              done,
	output logic [etpwm_pkg::TIME_W-1:0]      quotient
);

	localparam int unsigned DW  = etpwm_pkg::TIME_W;
	localparam int unsigned SW  = etpwm_pkg::STEPS_W;
	localparam int unsigned CW  = $clog2(DW);

	logic [DW-1:0] dvd_q;
	logic [DW-1:0] quo_q;
	logic [SW-1:0] rem_q;
	logic [SW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [SW:0]   trial;
	logic          fits;

	// Trial subtract of the shifted partial remainder
	assign trial = {rem_q, dvd_q[DW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			quo_q <= {quo_q[DW-2:0], fits};
			rem_q <= fits ? SW'(trial - {1'b0, dvs_q}) : trial[SW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== sv/encoder_triggered_pwm_ramp_profile_unit.sv =====
// Top level of the encoder triggered trapezoidal PWM ramp profile unit.
//
// Usage: each input transaction (cmd, encoder_count, now_ms) is a start command
// (cmd=1) or an update tick (cmd=0); each yields exactly one output transaction
// (pwm_out, reverse_dir, decelerating, ramp_done). Both channels use valid/stall;
// in_stall is high while an item is in work, so one item is processed at a time.
// An accepted item passes through PREP, PHASE and RAMP to DONE when no ramp step is
// taken; a step adds MUL, DSTART, DWAIT and UPD between RAMP and DONE. A step waits
// on the serial divider by ramp_steps, which retires one quotient bit per cycle over
// 32 bits. A new item is accepted only after the previous one has left DONE.
// If out_stall holds a result, the unit finishes the next item and then waits
// with the new result until the output register frees up.
// Configuration registers are written through cfg_valid/cfg_ready (always ready), index
// cfg_index, data cfg_data; writes must only be made while the unit is idle (unchecked).
// Reset (arst_n low, asynchronous) restores register defaults and clears the
// ramp state: acceleration phase, step counter 0, PWM 0, no ramp finished.
module encoder_triggered_pwm_ramp_profile_unit #(
	parameter int unsigned PWM_WIDTH = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 cmd,
	input  logic signed [etpwm_pkg::COUNT_W-1:0] encoder_count,
	input  logic [etpwm_pkg::TIME_W-1:0]         now_ms,
	// output channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [PWM_WIDTH-1:0]                 pwm_out,
	output logic                                 reverse_dir,
	output logic                                 decelerating,
	output logic                                 ramp_done,
	// configuration write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [etpwm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [etpwm_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int unsigned TW  = etpwm_pkg::TIME_W;
	localparam int unsigned SCW = etpwm_pkg::STEP_CNT_W;
	localparam int unsigned PRW = etpwm_pkg::PULSES_W + etpwm_pkg::FRAC_W;
	localparam int unsigned MW  = TW + SCW;

	// Sequencer states
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_PREP   = 4'd1;
	localparam logic [3:0] S_PHASE  = 4'd2;
	localparam logic [3:0] S_RAMP   = 4'd3;
	localparam logic [3:0] S_MUL    = 4'd4;
	localparam logic [3:0] S_DSTART = 4'd5;
	localparam logic [3:0] S_DWAIT  = 4'd6;
	localparam logic [3:0] S_UPD    = 4'd7;
	localparam logic [3:0] S_DONE   = 4'd8;

	logic [PWM_WIDTH-1:0] initial_pwm;
	logic [PWM_WIDTH-1:0] target_pwm;
	logic [PWM_WIDTH-1:0] final_pwm;
	etpwm_pkg::cfg_t      cfg;

	logic [3:0]                          state_q;
	logic                                cmd_q;
	logic signed [etpwm_pkg::COUNT_W-1:0] count_q;
	logic [TW-1:0]                       now_q;
	logic [TW-1:0]                       ds_q;
	logic [TW-1:0]                       prod_q;
	logic                                decel_q;
	logic [SCW-1:0]                      step_q;
	logic [TW-1:0]                       last_q;
	logic [PWM_WIDTH-1:0]                cur_q;
	logic                                fin_q;
	logic                                out_valid_q;
	logic [PWM_WIDTH-1:0]                pwm_q;
	logic                                dir_q;
	logic                                dec_q;
	logic                                done_q;

	logic                 in_acc;
	logic                 out_free;
	logic [PRW-1:0]       ds_full;
	logic                 decel_c;
	logic                 do_switch;
	logic [PWM_WIDTH-1:0] a_sel;
	logic [PWM_WIDTH-1:0] b_sel;
	logic                 rising;
	logic [TW-1:0]        a_ext;
	logic [TW-1:0]        b_ext;
	logic [PWM_WIDTH-1:0] cur_eff;
	logic [TW-1:0]        last_eff;
	logic                 at_end;
	logic                 due;
	logic                 past;
	logic [TW-1:0]        diff;
	logic [MW-1:0]        mul_full;
	logic [TW-1:0]        sum;
	logic [SCW-1:0]       step_n;
	logic [etpwm_pkg::STEPS_W-1:0] divisor;
	logic                 div_start;
	logic                 div_done;
	logic [TW-1:0]        quotient;

	etpwm_cfg_regs #(
		.PWM_WIDTH (PWM_WIDTH)
	) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.initial_pwm (initial_pwm),
		.target_pwm  (target_pwm),
		.final_pwm   (final_pwm),
		.cfg         (cfg)
	);

	etpwm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	// Handshakes
	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid & ~in_stall;
	assign out_free  = ~out_valid_q | ~out_stall;
	assign div_start = (state_q == S_DSTART);
	assign divisor   = (cfg.ramp_steps == '0) ? etpwm_pkg::STEPS_W'(1) : cfg.ramp_steps;

	// Deceleration start point and phase switch
	assign ds_full   = PRW'(cfg.move_pulses) * PRW'(cfg.decel_fraction);
	assign decel_c   = cmd_q ? 1'b0 : decel_q;
	assign do_switch = ~decel_c &&
		($signed({{2{count_q[etpwm_pkg::COUNT_W-1]}}, count_q}) >= $signed({2'b00, ds_q}));

	// Ramp endpoints of the current phase
	assign rising = ~decel_q;
	assign a_sel  = decel_q ? target_pwm : initial_pwm;
	assign b_sel  = decel_q ? final_pwm  : target_pwm;
	assign a_ext  = TW'(a_sel);
	assign b_ext  = TW'(b_sel);

	// Ramp checks
	assign cur_eff  = (step_q == '0) ? a_sel : cur_q;
	assign last_eff = (step_q == '0) ? now_q : last_q;
	assign at_end   = rising ? (cur_eff >= b_sel) : (cur_eff <= b_sel);
	assign due      = (now_q - last_eff) >= TW'(cfg.step_interval_ms);
	assign past     = step_q > SCW'(cfg.ramp_steps);

	// Interpolation arithmetic, modulo 2^32
	assign diff     = rising ? (b_ext - a_ext) : (a_ext - b_ext);
	assign mul_full = MW'(diff) * MW'(step_q);
	assign sum      = rising ? (a_ext + quotient) : (a_ext - quotient);
	assign step_n   = step_q + 1'b1;

	// Sequencer and ramp state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			decel_q <= 1'b0;
			step_q  <= '0;
			last_q  <= '0;
			cur_q   <= '0;
			fin_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) state_q <= S_PREP;
				end
				S_PREP: state_q <= S_PHASE;
				S_PHASE: begin
					decel_q <= decel_c | do_switch;
					if (cmd_q || do_switch) begin
						step_q <= '0;
						fin_q  <= 1'b0;
					end
					state_q <= S_RAMP;
				end
				S_RAMP: begin
					if (fin_q) begin
						cur_q   <= b_sel;
						state_q <= S_DONE;
					end else begin
						last_q <= last_eff;
						if (at_end) begin
							cur_q   <= b_sel;
							fin_q   <= 1'b1;
							state_q <= S_DONE;
						end else if (due) begin
							cur_q   <= cur_eff;
							state_q <= S_MUL;
						end else if (past) begin
							cur_q   <= b_sel;
							fin_q   <= 1'b1;
							state_q <= S_DONE;
						end else begin
							cur_q   <= cur_eff;
							state_q <= S_DONE;
						end
					end
				end
				S_MUL:    state_q <= S_DSTART;
				S_DSTART: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (div_done) state_q <= S_UPD;
				end
				S_UPD: begin
					step_q <= step_n;
					last_q <= now_q;
					if (step_n > SCW'(cfg.ramp_steps)) begin
						cur_q <= b_sel;
						fin_q <= 1'b1;
					end else begin
						cur_q <= sum[PWM_WIDTH-1:0];
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Item capture and arithmetic registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q   <= cmd;
			count_q <= encoder_count;
			now_q   <= now_ms;
		end
		if (state_q == S_PREP) ds_q <= ds_full[PRW-1:8];
		if (state_q == S_MUL)  prod_q <= mul_full[TW-1:0];
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			pwm_q  <= cur_q;
			dir_q  <= cfg.backward;
			dec_q  <= decel_q;
			done_q <= fin_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign pwm_out      = pwm_q;
	assign reverse_dir  = dir_q;
	assign decelerating = dec_q;
	assign ramp_done    = done_q;

	// A finished ramp always sits at its end value
	a_fin_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && fin_q) |-> (cur_q == b_sel))
		else $error("finished ramp not at end value");

	// Divider completes only while the sequencer waits for it
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DWAIT))
		else $error("divider done outside wait state");

	// An accepted item starts the sequence
	a_accept_seq: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == S_PREP))
		else $error("accepted item did not start sequence");

	// A taken step never leaves the counter at zero
	a_step_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD) |=> (step_q != '0))
		else $error("step counter did not advance");

endmodule
